// ----- rtl/core/fvt_pkg.sv -----
`timescale 1ns / 1ps
package fvt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int TAB_BITS  = 8;
	localparam int TAB_N     = 1 << TAB_BITS;
	localparam int DATA_W    = 32;
	localparam int TAB_W     = 34;
	localparam int FRC_W     = 32 - TAB_BITS;
	localparam int PROD_W    = TAB_W + FRC_W;
	localparam int K_W       = 32 - FRAC_BITS;
	localparam int LNQ_W     = 40;
	localparam int NUM_W     = 64;
	localparam int DEN_W     = 34;
	localparam int QUO_W     = 33;

	localparam logic [63:0] LN2_Q32   = 64'd2977044472;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

	localparam logic [DATA_W-1:0] FX_ONE  = DATA_W'(1) << FRAC_BITS;
	localparam logic [DATA_W-1:0] FX_HALF = DATA_W'(1) << (FRAC_BITS - 1);
	localparam logic [DATA_W-1:0] FX_MIN  = 32'h8000_0000;
	localparam logic [DATA_W-1:0] FX_MAX  = 32'h7FFF_FFFF;

	localparam logic [2:0] MODE_DIRECT = 3'd0;
	localparam logic [2:0] MODE_NORM   = 3'd1;
	localparam logic [2:0] MODE_STD    = 3'd2;
	localparam logic [2:0] MODE_LOG    = 3'd3;
	localparam logic [2:0] MODE_BIN    = 3'd4;
	localparam logic [2:0] MODE_SIG    = 3'd5;

	typedef enum logic [1:0] {
		OP_FIX,
		OP_SCALE,
		OP_LOG,
		OP_SIG
	} op_t;

	typedef struct packed {
		logic [2:0]        mode;
		logic [DATA_W-1:0] minimum;
		logic [DATA_W-1:0] maximum;
		logic [DATA_W-1:0] mean;
		logic [DATA_W-1:0] deviation;
		logic [DATA_W-1:0] fallback;
	} cfg_t;

	// sideband that rides along the dividers
	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] res;
		logic              sat;
		logic              dom;
		logic              neg;
		logic [K_W-1:0]    k;
	} side_t;

	typedef logic [TAB_W-1:0] tab_t [0:TAB_N];

	// ln(1 + i/N) = 2 atanh(i / (2N + i)), Q32
	function automatic tab_t build_ln();
		tab_t t;
		logic [63:0] z, z2, term, sum;
		for (int i = 0; i <= TAB_N; i++) begin
			z = (64'(i) << 32) / 64'(2 * TAB_N + i);
			z2 = (z * z) >> 32;
			term = z;
			sum = z;
			for (int k = 1; k <= 24; k++) begin
				term = (term * z2) >> 32;
				sum = sum + term / 64'(2 * k + 1);
			end
			t[i] = TAB_W'(sum << 1);
		end
		return t;
	endfunction

	// 2^(i/N) by power series of e^y, Q32
	function automatic tab_t build_exp2();
		tab_t t;
		logic [63:0] y, tm, s;
		for (int i = 0; i <= TAB_N; i++) begin
			y = (64'(i) * LN2_Q32) >> TAB_BITS;
			tm = 64'h1_0000_0000;
			s = 64'h1_0000_0000;
			for (int n = 1; n <= 20; n++) begin
				tm = ((tm * y) >> 32) / 64'(n);
				s = s + tm;
			end
			t[i] = TAB_W'(s);
		end
		return t;
	endfunction

	localparam tab_t LN_TAB   = build_ln();
	localparam tab_t EXP2_TAB = build_exp2();

endpackage

// ----- rtl/core/fvt_front.sv -----
`timescale 1ns / 1ps
module fvt_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  fvt_pkg::cfg_t                cfg,
	input  logic                         item_valid,
	input  logic                         value_absent,
	input  logic [31:0]                  sample,
	output logic                         op_valid,
	output logic [fvt_pkg::NUM_W-1:0]    op_num,
	output logic [fvt_pkg::DEN_W-1:0]    op_den,
	output fvt_pkg::side_t               op_side
);
	import fvt_pkg::*;

	typedef struct packed {
		op_t                      op;
		logic [DATA_W-1:0]        res;
		logic                     dom;
		logic                     neg;
		logic [32:0]              a;
		logic [31:0]              dsor;
		logic [NUM_W-1:0]         num;
		logic [4:0]               e;
		logic [K_W-1:0]           k;
		logic [TAB_W-1:0]         lo;
		logic [TAB_W-1:0]         hi;
		logic [FRC_W-1:0]         frc;
		logic [PROD_W-1:0]        prod;
		logic signed [LNQ_W-1:0]  lnb;
	} fr_t;

	fr_t st_s1, st_s2, st_s3, st_s4;
	fr_t nx1, nx2, nx3, nx4;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [NUM_W-1:0] num_s5, nx_num;
	logic [DEN_W-1:0] den_s5, nx_den;
	side_t side_s5, nx_side;

	// S1: mode decode and special cases
	always_comb begin
		logic signed [32:0] sx, mn, mx, mu, dv, rng, x;
		sx = {sample[31], sample};
		mn = {cfg.minimum[31], cfg.minimum};
		mx = {cfg.maximum[31], cfg.maximum};
		mu = {cfg.mean[31], cfg.mean};
		dv = {cfg.deviation[31], cfg.deviation};
		rng = mx - mn;
		x = sx + $signed({1'b0, FX_ONE});
		nx1 = '0;
		nx1.op = OP_FIX;
		if (value_absent) begin
			nx1.res = cfg.fallback;
		end else begin
			unique case (cfg.mode)
				MODE_NORM: begin
					if (rng <= 0) begin
						nx1.res = FX_HALF;
					end else begin
						nx1.op = OP_SCALE;
						nx1.a = sx - mn;
						nx1.dsor = rng[31:0];
					end
				end
				MODE_STD: begin
					if (dv <= 0) begin
						nx1.res = '0;
					end else begin
						nx1.op = OP_SCALE;
						nx1.a = sx - mu;
						nx1.dsor = dv[31:0];
					end
				end
				MODE_LOG: begin
					if (x <= 0) begin
						nx1.res = FX_MIN;
						nx1.dom = 1'b1;
					end else begin
						nx1.op = OP_LOG;
						nx1.a = x;
					end
				end
				MODE_BIN: begin
					nx1.res = (sx > $signed({1'b0, FX_HALF})) ? FX_ONE : '0;
				end
				MODE_SIG: begin
					nx1.op = OP_SIG;
					nx1.neg = sample[31];
					nx1.a = sample[31] ? -sx : sx;
				end
				default: begin
					nx1.res = sample;
				end
			endcase
		end
	end

	// S2: magnitude and dividend, leading one, log2(e) product
	always_comb begin
		logic [32:0] mag;
		mag = st_s1.a[32] ? -st_s1.a : st_s1.a;
		nx2 = st_s1;
		unique case (st_s1.op)
			OP_SCALE: begin
				nx2.neg = st_s1.a[32];
				nx2.num = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(st_s1.dsor >> 1);
			end
			OP_LOG: begin
				for (int i = 0; i < 32; i++) begin
					if (st_s1.a[i]) nx2.e = 5'(i);
				end
			end
			OP_SIG: begin
				nx2.num = NUM_W'(st_s1.a[31:0]) * NUM_W'(LOG2E_Q30);
			end
			default: ;
		endcase
	end

	// S3: mantissa fraction, table read
	always_comb begin
		logic [31:0] f32;
		logic [TAB_BITS-1:0] idx;
		logic [TAB_BITS:0] idx_hi;
		logic signed [6:0] es;
		nx3 = st_s2;
		f32 = '0;
		es = 7'($signed({2'b00, st_s2.e})) - 7'(FRAC_BITS);
		unique case (st_s2.op)
			OP_LOG: begin
				f32 = 32'({st_s2.a[31:0], 32'h0} >> st_s2.e);
				nx3.lnb = es * $signed({1'b0, LN2_Q32[31:0]});
			end
			OP_SIG: begin
				nx3.k = K_W'(st_s2.num >> (FRAC_BITS + 30));
				f32 = st_s2.num[FRAC_BITS+29 -: 32];
			end
			default: ;
		endcase
		idx = f32[31:FRC_W];
		idx_hi = {1'b0, idx} + 1'b1;
		nx3.frc = f32[FRC_W-1:0];
		if (st_s2.op == OP_LOG) begin
			nx3.lo = LN_TAB[idx];
			nx3.hi = LN_TAB[idx_hi];
		end else begin
			nx3.lo = EXP2_TAB[idx];
			nx3.hi = EXP2_TAB[idx_hi];
		end
	end

	// S4: interpolation product
	always_comb begin
		nx4 = st_s3;
		nx4.prod = PROD_W'(st_s3.hi - st_s3.lo) * PROD_W'(st_s3.frc);
	end

	// S5: finish log, build divider operands
	always_comb begin
		logic [TAB_W-1:0] ip;
		logic signed [LNQ_W-1:0] lnq, lnr;
		ip = st_s4.lo + TAB_W'(st_s4.prod >> FRC_W);
		lnq = st_s4.lnb + $signed({{(LNQ_W-TAB_W){1'b0}}, ip});
		lnr = (lnq + $signed(LNQ_W'(64'd1 << (31 - FRAC_BITS)))) >>> (32 - FRAC_BITS);
		nx_side.op = st_s4.op;
		nx_side.res = st_s4.res;
		nx_side.sat = 1'b0;
		nx_side.dom = st_s4.dom;
		nx_side.neg = st_s4.neg;
		nx_side.k = st_s4.k;
		nx_num = '0;
		nx_den = DEN_W'(1);
		unique case (st_s4.op)
			OP_SCALE: begin
				nx_num = st_s4.num;
				nx_den = DEN_W'(st_s4.dsor);
			end
			OP_SIG: begin
				nx_num = NUM_W'(1) << (NUM_W - 1);
				nx_den = DEN_W'(ip >> 1);
			end
			OP_LOG: begin
				nx_side.op = OP_FIX;
				nx_side.res = lnr[DATA_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= nx1;
			st_s2 <= nx2;
			st_s3 <= nx3;
			st_s4 <= nx4;
			num_s5 <= nx_num;
			den_s5 <= nx_den;
			side_s5 <= nx_side;
		end
	end

	assign op_valid = v_s5;
	assign op_num = num_s5;
	assign op_den = den_s5;
	assign op_side = side_s5;

endmodule

// ----- rtl/core/fvt_div.sv -----
`timescale 1ns / 1ps
module fvt_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       op_valid,
	input  logic [fvt_pkg::NUM_W-1:0]  op_num,
	input  logic [fvt_pkg::DEN_W-1:0]  op_den,
	input  fvt_pkg::side_t             op_side,
	output logic                       res_valid,
	output logic [fvt_pkg::QUO_W-1:0]  res_quo,
	output logic                       res_ovf,
	output fvt_pkg::side_t             res_side
);
	import fvt_pkg::*;

	// stage 0 holds the overflow check, stages 1..QUO_W one quotient bit each
	logic             valid_s [0:QUO_W];
	logic [DEN_W-1:0] rem_s   [0:QUO_W];
	logic [DEN_W-1:0] den_s   [0:QUO_W];
	logic [QUO_W-1:0] low_s   [0:QUO_W];
	logic [QUO_W-1:0] quo_s   [0:QUO_W];
	logic             ovf_s   [0:QUO_W];
	side_t            side_s  [0:QUO_W];

	logic [DEN_W:0]   t_nx    [0:QUO_W-1];
	logic             ge_nx   [0:QUO_W-1];
	logic [DEN_W-1:0] rem_nx  [0:QUO_W-1];

	always_comb begin
		for (int j = 0; j < QUO_W; j++) begin
			t_nx[j] = {rem_s[j], low_s[j][QUO_W-1]};
			ge_nx[j] = t_nx[j] >= {1'b0, den_s[j]};
			rem_nx[j] = ge_nx[j] ? DEN_W'(t_nx[j] - {1'b0, den_s[j]}) : t_nx[j][DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= QUO_W; j++) valid_s[j] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= op_valid;
			for (int j = 0; j < QUO_W; j++) valid_s[j+1] <= valid_s[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DEN_W'(op_num >> QUO_W);
			den_s[0] <= op_den;
			low_s[0] <= op_num[QUO_W-1:0];
			quo_s[0] <= '0;
			ovf_s[0] <= (op_num >> QUO_W) >= NUM_W'(op_den);
			side_s[0] <= op_side;
			for (int j = 0; j < QUO_W; j++) begin
				rem_s[j+1] <= rem_nx[j];
				den_s[j+1] <= den_s[j];
				low_s[j+1] <= low_s[j] << 1;
				quo_s[j+1] <= {quo_s[j][QUO_W-2:0], ge_nx[j]};
				ovf_s[j+1] <= ovf_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign res_valid = valid_s[QUO_W];
	assign res_quo = quo_s[QUO_W];
	assign res_ovf = ovf_s[QUO_W];
	assign res_side = side_s[QUO_W];

endmodule

// ----- rtl/core/fvt_back.sv -----
`timescale 1ns / 1ps
module fvt_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       res_valid,
	input  logic [fvt_pkg::QUO_W-1:0]  res_quo,
	input  logic                       res_ovf,
	input  fvt_pkg::side_t             res_side,
	output logic                       op_valid,
	output logic [fvt_pkg::NUM_W-1:0]  op_num,
	output logic [fvt_pkg::DEN_W-1:0]  op_den,
	output fvt_pkg::side_t             op_side
);
	import fvt_pkg::*;

	logic             v_s1;
	logic [NUM_W-1:0] num_s1, nx_num;
	logic [DEN_W-1:0] den_s1, nx_den;
	side_t            side_s1, nx_side;

	// saturate the scaled quotient; build 2^(F+32) / (1 + 2^-u) operands
	always_comb begin
		logic [QUO_W-1:0] d;
		nx_side = res_side;
		nx_num = '0;
		nx_den = DEN_W'(1);
		d = (|res_side.k[K_W-1:6]) ? '0 : (res_quo >> res_side.k[5:0]);
		unique case (res_side.op)
			OP_SCALE: begin
				nx_side.op = OP_FIX;
				if (!res_side.neg) begin
					if (res_ovf || res_quo > QUO_W'(FX_MAX)) begin
						nx_side.sat = 1'b1;
						nx_side.res = FX_MAX;
					end else begin
						nx_side.res = res_quo[DATA_W-1:0];
					end
				end else begin
					if (res_ovf || res_quo > QUO_W'(FX_MIN)) begin
						nx_side.sat = 1'b1;
						nx_side.res = FX_MIN;
					end else begin
						nx_side.res = -res_quo[DATA_W-1:0];
					end
				end
			end
			OP_SIG: begin
				nx_den = (DEN_W'(1) << 32) + DEN_W'(d);
				nx_num = (NUM_W'(1) << (FRAC_BITS + 32)) + NUM_W'(nx_den >> 1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= nx_num;
			den_s1 <= nx_den;
			side_s1 <= nx_side;
		end
	end

	assign op_valid = v_s1;
	assign op_num = num_s1;
	assign op_den = den_s1;
	assign op_side = side_s1;

endmodule

// ----- rtl/core/feature_value_transform.sv -----
`timescale 1ns / 1ps
// From an accepted beat to result_valid: 5 front stages, 34 per divider,
// 1 between the dividers, 1 output register. Throughput: one beat per cycle
// unless a held result stalls; the two bit-per-stage dividers set the depth.
// arst_n clears all valid bits and loads register defaults (mode direct,
// maximum and deviation 1.0, others 0).
module feature_value_transform (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        feature_valid,
	output logic        feature_stall,
	input  logic        value_absent,
	input  logic [31:0] sample,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] result,
	output logic        saturated,
	output logic        domain_error,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import fvt_pkg::*;

	localparam logic [2:0] REG_MODE      = 3'd0;
	localparam logic [2:0] REG_MINIMUM   = 3'd1;
	localparam logic [2:0] REG_MAXIMUM   = 3'd2;
	localparam logic [2:0] REG_MEAN      = 3'd3;
	localparam logic [2:0] REG_DEVIATION = 3'd4;
	localparam logic [2:0] REG_FALLBACK  = 3'd5;

	cfg_t cfg_q;

	// pipeline advance: only blocked when the output register is held
	// and the last divider stage has a beat that would overwrite it
	logic en;

	logic             fa_valid, fb_valid, ra_valid, rb_valid;
	logic [NUM_W-1:0] fa_num, fb_num;
	logic [DEN_W-1:0] fa_den, fb_den;
	side_t            fa_side, fb_side, ra_side, rb_side;
	logic [QUO_W-1:0] ra_quo, rb_quo;
	logic             ra_ovf, rb_ovf;

	logic              out_valid_q;
	logic [DATA_W-1:0] result_q, fin_res;
	logic              sat_q, dom_q;

	assign en = !(rb_valid && out_valid_q && result_stall);
	assign feature_stall = !en;
	assign cfg_ready = 1'b1;

	// register file; user must write it only while the pipe is drained (not enforced)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= MODE_DIRECT;
			cfg_q.minimum <= '0;
			cfg_q.maximum <= FX_ONE;
			cfg_q.mean <= '0;
			cfg_q.deviation <= FX_ONE;
			cfg_q.fallback <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:      cfg_q.mode <= cfg_data[2:0];
				REG_MINIMUM:   cfg_q.minimum <= cfg_data;
				REG_MAXIMUM:   cfg_q.maximum <= cfg_data;
				REG_MEAN:      cfg_q.mean <= cfg_data;
				REG_DEVIATION: cfg_q.deviation <= cfg_data;
				REG_FALLBACK:  cfg_q.fallback <= cfg_data;
				default: ;
			endcase
		end
	end

	// decode, log/exp tables, dividend prep
	fvt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.cfg          (cfg_q),
		.item_valid   (feature_valid),
		.value_absent (value_absent),
		.sample       (sample),
		.op_valid     (fa_valid),
		.op_num       (fa_num),
		.op_den       (fa_den),
		.op_side      (fa_side)
	);

	// first divide: scaled quotient, or 2^63 / (2^f / 2) for sigmoid
	fvt_div u_div_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.op_valid  (fa_valid),
		.op_num    (fa_num),
		.op_den    (fa_den),
		.op_side   (fa_side),
		.res_valid (ra_valid),
		.res_quo   (ra_quo),
		.res_ovf   (ra_ovf),
		.res_side  (ra_side)
	);

	fvt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.res_valid (ra_valid),
		.res_quo   (ra_quo),
		.res_ovf   (ra_ovf),
		.res_side  (ra_side),
		.op_valid  (fb_valid),
		.op_num    (fb_num),
		.op_den    (fb_den),
		.op_side   (fb_side)
	);

	// second divide: logistic value for sigmoid; other modes only carry their sideband through
	fvt_div u_div_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.op_valid  (fb_valid),
		.op_num    (fb_num),
		.op_den    (fb_den),
		.op_side   (fb_side),
		.res_valid (rb_valid),
		.res_quo   (rb_quo),
		.res_ovf   (rb_ovf),
		.res_side  (rb_side)
	);

	// negative inputs give 1.0 minus the value; the second overflow flag cannot
	// fire for sigmoid operands
	always_comb begin
		logic [DATA_W-1:0] sq;
		sq = DATA_W'(rb_quo);
		if (rb_side.op == OP_SIG && !rb_ovf) begin
			fin_res = rb_side.neg ? (FX_ONE - sq) : sq;
		end else begin
			fin_res = rb_side.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !result_stall) begin
			out_valid_q <= rb_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !result_stall) begin
			result_q <= fin_res;
			sat_q <= rb_side.sat;
			dom_q <= rb_side.dom;
		end
	end

	assign result_valid = out_valid_q;
	assign result = result_q;
	assign saturated = sat_q;
	assign domain_error = dom_q;

endmodule

// ----- rtl/core/fvt_chk.sv -----
`timescale 1ns / 1ps
module fvt_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        feature_valid,
	input logic        feature_stall,
	input logic        value_absent,
	input logic [31:0] sample,
	input logic        result_valid,
	input logic        result_stall,
	input logic [31:0] result,
	input logic        saturated,
	input logic        domain_error,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [2:0]  cfg_index,
	input logic [31:0] cfg_data
);

	// a held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result)
			&& $stable(saturated) && $stable(domain_error))
		else $error("held result changed");

	// input only backs up behind a blocked output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		feature_stall |-> result_valid && result_stall)
		else $error("input stalled without output back-pressure");

	// log domain error answers the most negative value, never saturated
	a_domain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && domain_error |-> result == 32'h8000_0000 && !saturated)
		else $error("domain error with wrong result");

endmodule

bind feature_value_transform fvt_chk u_fvt_chk (.*);

// ----- bench/fvt_checker.sv -----
`timescale 1ns / 1ps
module fvt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        feature_valid,
	input  logic        feature_stall,
	input  logic        value_absent,
	input  logic [31:0] sample,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [31:0] result,
	input  logic        saturated,
	input  logic        domain_error,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          checked
);
	import fvt_pkg::*;

	typedef struct packed {
		logic [31:0] value;
		logic        sat;
		logic        dom;
	} outcome_t;

	localparam int IDX_MODE = 0;
	localparam int IDX_MIN  = 1;
	localparam int IDX_MAX  = 2;
	localparam int IDX_MEAN = 3;
	localparam int IDX_DEV  = 4;
	localparam int IDX_FALL = 5;

	logic [2:0]  r_mode;
	logic [31:0] r_min, r_max, r_mean, r_dev, r_fall;
	logic [63:0] ln_lut [0:256];
	logic [63:0] exp_lut [0:256];
	outcome_t    awaited [$];

	initial begin
		logic [63:0] z, z2, term, acc, y, t, s;
		for (int i = 0; i <= 256; i++) begin
			z = (64'(i) << 32) / 64'(512 + i);
			z2 = (z * z) >> 32;
			term = z;
			acc = z;
			for (int k = 1; k <= 24; k++) begin
				term = (term * z2) >> 32;
				acc = acc + term / 64'(2 * k + 1);
			end
			ln_lut[i] = acc << 1;
			y = (64'(i) * 64'd2977044472) >> 8;
			t = 64'h1_0000_0000;
			s = t;
			for (int n = 1; n <= 20; n++) begin
				t = ((t * y) >> 32) / 64'(n);
				s = s + t;
			end
			exp_lut[i] = s;
		end
	end

	function automatic logic [63:0] lerp(input bit use_ln, input logic [63:0] f32);
		logic [63:0] idx, rem, lo, hi;
		idx = (f32 >> 24) & 64'hFF;
		rem = f32 & 64'hFF_FFFF;
		lo = use_ln ? ln_lut[idx] : exp_lut[idx];
		hi = use_ln ? ln_lut[idx+1] : exp_lut[idx+1];
		return lo + (((hi - lo) * rem) >> 24);
	endfunction

	function automatic outcome_t ratio(input longint diff, input longint den);
		outcome_t o;
		logic [63:0] mag, q;
		o = '0;
		mag = diff < 0 ? -diff : diff;
		q = ((mag << 16) + 64'(den) / 2) / 64'(den);
		if (diff >= 0) begin
			if (q > 64'h7FFF_FFFF) begin
				o.value = 32'h7FFF_FFFF;
				o.sat = 1;
			end else
				o.value = q[31:0];
		end else begin
			if (q > 64'h8000_0000) begin
				o.value = 32'h8000_0000;
				o.sat = 1;
			end else
				o.value = -q[31:0];
		end
		return o;
	endfunction

	function automatic outcome_t transform(input logic absent, input logic [31:0] smp);
		outcome_t o;
		longint s, x, lnq, range;
		logic [63:0] ux, f32, u, k, p, d, den, q;
		int e;
		o = '0;
		s = longint'($signed(smp));
		if (absent) begin
			o.value = r_fall;
			return o;
		end
		case (r_mode)
			MODE_NORM: begin
				range = longint'($signed(r_max)) - longint'($signed(r_min));
				if (range <= 0) o.value = FX_HALF;
				else o = ratio(s - longint'($signed(r_min)), range);
			end
			MODE_STD: begin
				if ($signed(r_dev) <= 0) o.value = 0;
				else o = ratio(s - longint'($signed(r_mean)), longint'($signed(r_dev)));
			end
			MODE_LOG: begin
				x = s + 65536;
				if (x <= 0) begin
					o.value = FX_MIN;
					o.dom = 1;
				end else begin
					ux = x;
					e = 0;
					while (e < 40 && (ux >> (e + 1)) != 0) e++;
					f32 = (ux << (32 - e)) - 64'h1_0000_0000;
					lnq = longint'(e - 16) * 64'd2977044472 + longint'(lerp(1, f32));
					q = ((64'(lnq) + (64'd64 << 32)) + (64'd1 << 15)) >> 16;
					o.value = 32'(q - (64'd64 << 16));
				end
			end
			MODE_BIN: o.value = s > 32768 ? FX_ONE : 32'd0;
			MODE_SIG: begin
				ux = s < 0 ? -s : s;
				u = ux * 64'd1549082005;
				k = u >> 46;
				f32 = (u & ((64'd1 << 46) - 1)) >> 14;
				p = lerp(0, f32);
				d = (64'd1 << 63) / (p >> 1);
				d = k >= 64 ? 64'd0 : d >> k;
				den = 64'h1_0000_0000 + d;
				q = ((64'd1 << 48) + den / 2) / den;
				o.value = s < 0 ? FX_ONE - q[31:0] : q[31:0];
			end
			default: o.value = smp;
		endcase
		return o;
	endfunction

	assign pending = awaited.size();

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			r_mode <= MODE_DIRECT;
			r_min <= 0;
			r_max <= FX_ONE;
			r_mean <= 0;
			r_dev <= FX_ONE;
			r_fall <= 0;
			errors <= 0;
			checked <= 0;
			awaited.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				case (int'(cfg_index))
					IDX_MODE: r_mode <= cfg_data[2:0];
					IDX_MIN:  r_min <= cfg_data;
					IDX_MAX:  r_max <= cfg_data;
					IDX_MEAN: r_mean <= cfg_data;
					IDX_DEV:  r_dev <= cfg_data;
					IDX_FALL: r_fall <= cfg_data;
					default: ;
				endcase
			if (feature_valid && !feature_stall)
				awaited.push_back(transform(value_absent, sample));
			if (result_valid && !result_stall) begin
				checked <= checked + 1;
				if (awaited.size() == 0) begin
					$display("%0t: unexpected result %h", $time, result);
					errors <= errors + 1;
				end else begin
					want = awaited.pop_front();
					if (want.value !== result || want.sat !== saturated
							|| want.dom !== domain_error) begin
						$display("%0t: expected %h sat %b dom %b, got %h sat %b dom %b",
							$time, want.value, want.sat, want.dom,
							result, saturated, domain_error);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import fvt_pkg::*;

	localparam int LATENCY   = 75;
	localparam int WDOG_MAX  = 20000;
	localparam int IDX_MODE  = 0;
	localparam int IDX_MIN   = 1;
	localparam int IDX_MAX   = 2;
	localparam int IDX_MEAN  = 3;
	localparam int IDX_DEV   = 4;
	localparam int IDX_FALL  = 5;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        feature_valid = 0;
	logic        feature_stall;
	logic        value_absent = 0;
	logic [31:0] sample = 0;
	logic        result_valid;
	logic        result_stall = 0;
	logic [31:0] result;
	logic        saturated;
	logic        domain_error;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 0;
	logic [31:0] cfg_data = 0;
	int          errors, pending, checked;

	// idle percentages for sender and receiver, changed per phase
	int send_idle = 0;
	int recv_idle = 0;
	bit hold_off = 0;
	int idle_cycles = 0;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	feature_value_transform dut (.*);

	fvt_checker chk (.*);

	// receiver: random stall, or a long hold-off when asked
	always @(posedge clk)
		result_stall <= hold_off || ($urandom_range(99) < recv_idle);

	// watchdog: cycles with no beat on any channel
	always @(posedge clk) begin
		if ((feature_valid && !feature_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("watchdog: no progress");
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic write_reg(input int idx, input logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= 3'(idx);
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	// wait until every expected result is back, then let the pipe drain
	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	// one beat; a random gap before it, valid kept high between back-to-back beats
	task automatic send(input logic absent, input logic [31:0] val);
		while ($urandom_range(99) < send_idle) begin
			feature_valid <= 0;
			@(posedge clk);
		end
		feature_valid <= 1;
		value_absent <= absent;
		sample <= val;
		do @(posedge clk); while (feature_stall);
	endtask

	task automatic idle_input();
		feature_valid <= 0;
		@(posedge clk);
	endtask

	// samples biased toward interesting regions
	function automatic logic [31:0] pick_sample();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
			2: return 32'($signed($urandom_range(1024)) - 512 - 65536);
			3: return 32'($signed($urandom_range(4096)) - 2048 + 32768);
			4: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return 32'($signed($urandom_range(200000)) - 100000);
		endcase
	endfunction

	logic [31:0] edge_vals [12] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
		32'hFFFF_0000, 32'hFFFE_FFFF, 32'h0000_8000, 32'h0000_8001, 32'h0001_0000,
		32'hFFFF_0001, 32'h0100_0000, 32'hFF00_0000};

	initial begin
		int phase;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: every mode over the field extremes, absent values too
		for (int m = 0; m < 8; m++) begin
			write_reg(IDX_MODE, 32'(m));
			send(1, 32'h1234_5678);
			for (int i = 0; i < 12; i++) send(0, edge_vals[i]);
			idle_input();
			drain();
		end

		// empty range, empty deviation, and saturating quotients
		write_reg(IDX_MIN, 32'h0001_0000);
		write_reg(IDX_MAX, 32'h0001_0000);
		write_reg(IDX_DEV, 32'h0);
		write_reg(IDX_FALL, 32'hDEAD_BEEF);
		write_reg(IDX_MODE, 32'(MODE_NORM));
		send(0, 32'h0002_0000);
		send(1, 32'h0);
		idle_input();
		drain();
		write_reg(IDX_MODE, 32'(MODE_STD));
		send(0, 32'h0002_0000);
		idle_input();
		drain();
		write_reg(IDX_MIN, 32'h8000_0000);
		write_reg(IDX_MAX, 32'h8000_0001);
		write_reg(IDX_MEAN, 32'h7FFF_FFFF);
		write_reg(IDX_DEV, 32'h0000_0001);
		send(0, 32'h8000_0000);
		send(0, 32'h7FFF_FFFF);
		idle_input();
		drain();
		write_reg(IDX_MODE, 32'(MODE_NORM));
		send(0, 32'h7FFF_FFFF);
		send(0, 32'h8000_0000);
		idle_input();
		drain();

		// random phases: idling pattern changes; configuration between phases
		for (phase = 0; phase < 14; phase++) begin
			case (phase % 4)
				0: begin send_idle = 0;  recv_idle = 0;  end
				1: begin send_idle = 60; recv_idle = 0;  end
				2: begin send_idle = 0;  recv_idle = 60; end
				default: begin send_idle = 30; recv_idle = 30; end
			endcase
			write_reg(IDX_MODE, 32'($urandom_range(7)));
			write_reg(IDX_MIN, $urandom_range(1) ? pick_sample() : 32'($signed($urandom_range(131072)) - 65536));
			write_reg(IDX_MAX, $urandom_range(3) == 0 ? pick_sample()
				: 32'($signed($urandom_range(1 << 20)) + 65536));
			write_reg(IDX_MEAN, pick_sample());
			write_reg(IDX_DEV, $urandom_range(5) == 0 ? pick_sample()
				: 32'($urandom_range(1 << 20) + 1));
			write_reg(IDX_FALL, $urandom);
			// long receiver hold-off while input keeps coming
			if (phase == 5)
				fork
					begin
						hold_off = 1;
						repeat (400) @(posedge clk);
						hold_off = 0;
					end
				join_none
			for (int n = 0; n < 125; n++)
				send($urandom_range(9) == 0, pick_sample());
			idle_input();
			drain();
		end

		$display("covered all modes incl. unused, absent, empty range/deviation, log domain,");
		$display("saturation, 14 random phases, %0d results checked", checked);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
